FILE: rtl/assert_macros.svh
// Assertion helpers used by pixelate_block_average.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants and types of the block-average pixelation engine.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_BLOCK  = 64;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = $clog2(MAX_WIDTH);         // column / group index
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int BS_W    = 7;                         // block_size register
    localparam int DIM_W   = 13;                        // width / height registers
    localparam int GRP_W   = 14;                        // one group sum per colour
    localparam int SUM_W   = 20;                        // one block sum per colour
    localparam int MEM_W   = 3 * SUM_W;
    localparam int DIV_W   = SUM_W;                     // dividend width
    localparam int DVS_W   = 13;                        // divisor width (bs squared)
    localparam int LANES   = 4;                         // r, g, b, band index
    localparam int CNT_W   = $clog2(DIV_W + 1);

    localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DVS_W-1:0]  area;
        logic [BS_W-1:0]   bs;
    } pba_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pba_div_rsp_t;

endpackage

FILE: rtl/pba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_div
// Restoring divider, one quotient bit per cycle over four lanes: three colour
// sums by the block area, and the row index by the block size.
// ----------------------------------------------------------------------------
module pba_div
    import pba_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pba_div_req_t                req,
    input  logic [LANES-1:0][DIV_W-1:0] dividend,
    output pba_div_rsp_t                rsp,
    output logic [LANES-1:0][DIV_W-1:0] quotient
);

    logic [LANES-1:0][DIV_W-1:0] num_reg;
    logic [LANES-1:0][DVS_W:0]   rem_reg;
    logic [LANES-1:0][DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [LANES-1:0][DVS_W:0]   trial;
    logic [LANES-1:0]            fits;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_reg[l][DVS_W-1:0], num_reg[l][DIV_W-1]};
            fits[l]  = trial[l] >= {1'b0, dvs_reg[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into num_reg as dividend bits shift out
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            for (int l = 0; l < LANES - 1; l++) dvs_reg[l] <= req.area;
            dvs_reg[LANES-1] <= DVS_W'(req.bs);
        end else if (busy_reg) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= fits[l] ? trial[l] - {1'b0, dvs_reg[l]} : trial[l];
                num_reg[l] <= {num_reg[l][DIV_W-2:0], fits[l]};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = num_reg;

endmodule

FILE: rtl/pixelate_block_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixelate_block_average
// Sums RGB pixels over square blocks and emits each block's truncated mean.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_        in   tdata: red, green, blue; tuser: frame_start
// m_        out  tdata: avg_red, avg_green, avg_blue, block_row, block_column;
//                tuser: frame_done
// cfg_      in   write only: block_size, image_width, image_height
//
// A pixel that does not close a group only updates the sums and counters. A pixel
// that closes a group also reads the band-sum memory, then writes it back.
// Closing a block adds the divider, then a load of the output register.
// Reset is synchronous; the band-sum memory is not cleared.
// A pixel may be taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module pixelate_block_average
    import pba_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // avg_red, avg_green, avg_blue, block_row, block_column
    output logic        m_tuser,   // frame_done
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

`include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [BS_W-1:0]  bs_cfg_reg;
    logic [DIM_W-1:0] width_cfg_reg, height_cfg_reg;

    logic [2:0][GRP_W-1:0] rgs_reg;
    logic [BS_W-1:0]       gfill_reg, bfill_reg;
    logic [COL_W-1:0]      pcol_reg, gidx_reg;
    logic [ROW_W-1:0]      prow_reg;

    logic [MEM_W-1:0]      mem [MAX_WIDTH];
    logic [MEM_W-1:0]      rd_reg;

    logic [2:0][GRP_W-1:0] g_reg;
    logic [BS_W-1:0]       vpad_reg, bs_reg;
    logic [DVS_W-1:0]      area_reg;
    logic                  band_end_reg, first_reg, fdone_reg;
    logic [COL_W-1:0]      gi_reg;
    logic [ROW_W-1:0]      row_reg;

    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;

    // clamped registers
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] width, height;
    always_comb begin
        bs     = (bs_cfg_reg == '0) ? BS_W'(1)
               : (bs_cfg_reg > BS_W'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : bs_cfg_reg;
        width  = (width_cfg_reg == '0) ? DIM_W'(1)
               : (width_cfg_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_cfg_reg;
        height = (height_cfg_reg == '0) ? DIM_W'(1)
               : (height_cfg_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_cfg_reg;
    end

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // pixel datapath; a frame start zeroes the counters first
    logic                  fs;
    logic [2:0][7:0]       px;
    logic [2:0][GRP_W-1:0] rgs, sum, g;
    logic [BS_W-1:0]       gf, bf, pad, vpad;
    logic [COL_W-1:0]      pc, gi;
    logic [ROW_W-1:0]      pr;
    logic [BS_W:0]         gf1, bf1;
    logic                  row_end, last_row, group_close, band_end;

    always_comb begin
        fs  = s_tuser;
        rgs = fs ? '0 : rgs_reg;
        gf  = fs ? '0 : gfill_reg;
        bf  = fs ? '0 : bfill_reg;
        pc  = fs ? '0 : pcol_reg;
        gi  = fs ? '0 : gidx_reg;
        pr  = fs ? '0 : prow_reg;
        gf1 = {1'b0, gf} + 1'b1;
        bf1 = {1'b0, bf} + 1'b1;
        row_end     = ({1'b0, pc} + 1'b1) >= width;
        last_row    = ({1'b0, pr} + 1'b1) >= height;
        group_close = (gf1 >= {1'b0, bs}) || row_end;
        band_end    = (bf1 >= {1'b0, bs}) || last_row;
        pad  = (gf1 < {1'b0, bs}) ? BS_W'({1'b0, bs} - gf1) : '0;
        vpad = (bf1 < {1'b0, bs}) ? BS_W'({1'b0, bs} - bf1) : '0;
        for (int c = 0; c < 3; c++) begin
            px[c]  = s_tdata[8*c +: 8];
            sum[c] = rgs[c] + GRP_W'(px[c]);
            g[c]   = sum[c] + GRP_W'(px[c] * pad);
        end
    end

    // read-modify-write of the band sums
    logic [2:0][SUM_W-1:0] acc;
    logic                  div_start;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = (first_reg ? '0 : rd_reg[SUM_W*c +: SUM_W]) + SUM_W'(g_reg[c])
                   + (band_end_reg ? SUM_W'(g_reg[c] * vpad_reg) : '0);
        end
        div_start = (state_reg == S_RMW) && band_end_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept && group_close) rd_reg <= mem[gi];
        if (state_reg == S_RMW) mem[gi_reg] <= {acc[2], acc[1], acc[0]};
    end

    pba_div_req_t                div_req;
    pba_div_rsp_t                div_rsp;
    logic [LANES-1:0][DIV_W-1:0] div_num, div_quo;

    always_comb begin
        div_req.start = div_start;
        div_req.area  = area_reg;
        div_req.bs    = bs_reg;
        for (int c = 0; c < 3; c++) div_num[c] = acc[c];
        div_num[LANES-1] = DIV_W'(row_reg);
    end

    pba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_num),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    logic out_load;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept && group_close) state_next = S_RMW;
            S_RMW:  state_next = band_end_reg ? S_DIV : S_IDLE;
            S_DIV:  if (div_rsp.done) state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            bs_cfg_reg     <= BS_W'(8);
            width_cfg_reg  <= DIM_W'(640);
            height_cfg_reg <= DIM_W'(480);
            rgs_reg        <= '0;
            gfill_reg      <= '0;
            bfill_reg      <= '0;
            pcol_reg       <= '0;
            prow_reg       <= '0;
            gidx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_BLOCK_SIZE:   bs_cfg_reg     <= cfg_wdata[BS_W-1:0];
                    REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                if (group_close) begin
                    rgs_reg   <= '0;
                    gfill_reg <= '0;
                    gidx_reg  <= row_end ? '0 : gi + 1'b1;
                end else begin
                    rgs_reg   <= sum;
                    gfill_reg <= gf + 1'b1;
                    gidx_reg  <= gi;
                end
                if (row_end) begin
                    pcol_reg <= '0;
                    if (last_row) begin
                        prow_reg  <= '0;
                        bfill_reg <= '0;
                    end else begin
                        prow_reg  <= pr + 1'b1;
                        bfill_reg <= band_end ? '0 : bf + 1'b1;
                    end
                end else begin
                    pcol_reg  <= pc + 1'b1;
                    prow_reg  <= pr;
                    bfill_reg <= bf;
                end
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // per-group context captured with the closing pixel
    always_ff @(posedge aclk) begin
        if (accept && group_close) begin
            g_reg        <= g;
            vpad_reg     <= vpad;
            bs_reg       <= bs;
            area_reg     <= DVS_W'(bs * bs);
            band_end_reg <= band_end;
            first_reg    <= (bf == '0);
            fdone_reg    <= row_end && last_row;
            gi_reg       <= gi;
            row_reg      <= pr;
        end
        if (out_load) begin
            out_data_reg <= {gi_reg, div_quo[LANES-1][COL_W-1:0],
                             div_quo[2][7:0], div_quo[1][7:0], div_quo[0][7:0]};
            out_user_reg <= fdone_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `ASSERT_NEXT(a_rmw_exit, state_reg == S_RMW, state_reg == S_IDLE || state_reg == S_DIV,
        "read-modify-write not followed by idle or divide")
    `ASSERT_SAME(a_div_done_state, div_rsp.done, state_reg == S_DIV,
        "divider finished outside the divide state")
    `ASSERT_SAME(a_fill_bound, 1'b1, gfill_reg < BS_W'(MAX_BLOCK) && bfill_reg < BS_W'(MAX_BLOCK),
        "group or band fill out of range")

endmodule
